### rtl/core/command_line_assembler_assert.svh
// Assertion macros for the command line assembler checkers.
`ifndef COMMAND_LINE_ASSEMBLER_ASSERT_SVH
`define COMMAND_LINE_ASSEMBLER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define CLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CLA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/cla_pkg.sv
// Shared constants and types of the command line assembler.
`default_nettype none
package cla_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int RX_W         = 8;
    localparam int CHAR_W       = 7;
    localparam int IDLE_W       = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [RX_W-1:0] CH_CR      = 8'h0D;
    localparam logic [RX_W-1:0] CH_LF      = 8'h0A;
    localparam logic [RX_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [RX_W-1:0] PRINT_HIGH = 8'h7E;

    localparam logic [IDLE_W-1:0] IDLE_TICKS_RESET = 16'd100;
    localparam logic [IDLE_W-1:0] IDLE_MAX         = 16'hFFFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    // Register index decoded from paddr[2].
    localparam logic REG_IDLE_TICKS = 1'b0;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

### rtl/core/cla_if.sv
// Valid/ready channel interfaces for command items and result items.
`default_nettype none
interface cla_in_if;
    import cla_pkg::*;
    logic            valid;
    logic            ready;
    logic            op;
    logic [RX_W-1:0] rx_byte;

    modport source (output valid, op, rx_byte, input ready);
    modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface cla_out_if;
    import cla_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAR_W-1:0] char_out;
    logic              last;

    modport source (output valid, kind, char_out, last, input ready);
    modport sink   (input valid, kind, char_out, last, output ready);
endinterface
`default_nettype wire

### rtl/core/cla_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/cla_front.sv
// Front end: takes bytes and ticks, builds the line, posts readout jobs.
`default_nettype none
module cla_front #(
    parameter int CAPACITY = cla_pkg::CAPACITY_DEF,
    localparam int LW      = $clog2(CAPACITY),
    localparam int AW      = $clog2(2 * CAPACITY),
    localparam int JW      = LW + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cla_in_if.sink                       i_cmd,
    input  logic [cla_pkg::IDLE_W-1:0]   i_idle_ticks,
    input  cla_pkg::t_q_stat             i_qstat,
    input  logic                         i_line_done,
    output logic                         o_push,
    output logic [JW-1:0]                o_job,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [cla_pkg::CHAR_W-1:0]   o_wdata
);
    import cla_pkg::*;

    logic [LW-1:0]     r_len, n_len;
    logic              r_disc, n_disc;
    logic              r_bank, n_bank;
    logic [IDLE_W-1:0] r_idle, n_idle;
    logic [1:0]        r_lines, n_lines;
    logic              accept;
    logic              push_line;
    logic              job_err;
    logic              is_eol;
    logic              is_print;
    logic [IDLE_W-1:0] idle_inc;

    // Both line banks pending means the current bank is still being read.
    assign i_cmd.ready = !i_qstat.full && (r_lines != 2'd2);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign is_eol   = (i_cmd.rx_byte == CH_CR) || (i_cmd.rx_byte == CH_LF);
    assign is_print = (i_cmd.rx_byte >= PRINT_LOW) && (i_cmd.rx_byte <= PRINT_HIGH);
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + IDLE_W'(1);

    always_comb begin
        n_len     = r_len;
        n_disc    = r_disc;
        n_bank    = r_bank;
        n_idle    = r_idle;
        push_line = 1'b0;
        job_err   = 1'b0;
        o_we      = 1'b0;
        if (accept) begin
            if (i_cmd.op == OP_BYTE) begin
                n_idle = '0;
                if (is_eol) begin
                    push_line = !r_disc && (r_len != '0);
                    n_len     = '0;
                    n_disc    = 1'b0;
                end else if (is_print) begin
                    if (r_len != LW'(CAPACITY - 1)) begin
                        if (!r_disc) begin
                            o_we  = 1'b1;
                            n_len = r_len + LW'(1);
                        end
                    end else begin
                        n_disc = 1'b1;
                    end
                end
            end else begin
                n_idle = idle_inc;
                if (idle_inc >= i_idle_ticks) begin
                    if (r_disc) begin
                        job_err = 1'b1;
                        n_len   = '0;
                        n_disc  = 1'b0;
                    end else if (r_len != '0) begin
                        push_line = 1'b1;
                        n_len     = '0;
                    end
                end
            end
        end
        // Advance to the other bank once a line is handed off.
        if (push_line) begin
            n_bank = ~r_bank;
        end
        case ({push_line, i_line_done})
            2'b10:   n_lines = r_lines + 2'd1;
            2'b01:   n_lines = r_lines - 2'd1;
            default: n_lines = r_lines;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_disc  <= 1'b0;
            r_bank  <= 1'b0;
            r_idle  <= '0;
            r_lines <= '0;
        end else begin
            r_len   <= n_len;
            r_disc  <= n_disc;
            r_bank  <= n_bank;
            r_idle  <= n_idle;
            r_lines <= n_lines;
        end
    end

    assign o_push  = push_line || job_err;
    assign o_job   = {job_err, r_bank, r_len};
    assign o_waddr = r_bank ? (AW'(CAPACITY) + AW'(r_len)) : AW'(r_len);
    assign o_wdata = i_cmd.rx_byte[CHAR_W-1:0];

endmodule
`default_nettype wire

### rtl/core/cla_queue.sv
// Two-entry job queue between the front end and the readout engine.
`default_nettype none
module cla_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output cla_pkg::t_q_stat o_stat
);
    import cla_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule
`default_nettype wire

### rtl/core/cla_back.sv
// Readout engine: turns jobs into result items, one line character a cycle while the result side is ready.
`default_nettype none
module cla_back #(
    parameter int CAPACITY = cla_pkg::CAPACITY_DEF,
    localparam int LW      = $clog2(CAPACITY),
    localparam int AW      = $clog2(2 * CAPACITY),
    localparam int JW      = LW + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cla_pkg::t_q_stat             i_qstat,
    input  logic [JW-1:0]                i_job,
    output logic                         o_pop,
    output logic                         o_re,
    output logic [AW-1:0]                o_raddr,
    input  logic [cla_pkg::CHAR_W-1:0]   i_rdata,
    output logic                         o_line_done,
    cla_out_if.source                    o_res
);
    import cla_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic              r_valid, n_valid;
    logic              r_kind, n_kind;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic              r_bank, n_bank;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_idx, n_idx;
    logic              load_ok;
    logic              is_last;
    logic              job_err;
    logic              job_bank;
    logic [LW-1:0]     job_len;
    logic              rd_bank;
    logic [LW-1:0]     rd_idx;

    assign job_err  = i_job[LW+1];
    assign job_bank = i_job[LW];
    assign job_len  = i_job[LW-1:0];

    assign load_ok = !r_valid || o_res.ready;
    assign is_last = (r_idx == r_len - LW'(1));

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid && !o_res.ready;
        n_kind      = r_kind;
        n_char      = r_char;
        n_last      = r_last;
        n_bank      = r_bank;
        n_len       = r_len;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        o_re        = 1'b0;
        o_line_done = 1'b0;
        rd_bank     = r_bank;
        rd_idx      = r_idx + LW'(1);
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    if (job_err) begin
                        if (load_ok) begin
                            n_valid = 1'b1;
                            n_kind  = KIND_ERR;
                            n_char  = '0;
                            n_last  = 1'b1;
                            o_pop   = 1'b1;
                        end
                    end else begin
                        // Take the line job and fetch its first character.
                        o_pop   = 1'b1;
                        n_bank  = job_bank;
                        n_len   = job_len;
                        n_idx   = '0;
                        o_re    = 1'b1;
                        rd_bank = job_bank;
                        rd_idx  = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (load_ok) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_CHAR;
                    n_char  = i_rdata;
                    n_last  = is_last;
                    if (is_last) begin
                        o_line_done = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_idx = r_idx + LW'(1);
                        o_re  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_kind  <= n_kind;
            r_char  <= n_char;
            r_last  <= n_last;
            r_bank  <= n_bank;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    assign o_raddr        = rd_bank ? (AW'(CAPACITY) + AW'(rd_idx)) : AW'(rd_idx);
    assign o_res.valid    = r_valid;
    assign o_res.kind     = r_kind;
    assign o_res.char_out = r_char;
    assign o_res.last     = r_last;

endmodule
`default_nettype wire

### rtl/core/command_line_assembler.sv
// Top level of the command line assembler: config register and datapath wiring.
//
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        op, rx_byte
//  o_res     out  valid/ready        kind, char_out, last
//  apb       in   psel/penable       paddr, pwdata, prdata (idle_ticks at 0x0)
//
// A byte or tick item is handled by the front end in the cycle it is accepted.
// A finished line is read out of the two-bank line RAM at one character
// per cycle through its single read port while the result side is ready.
// The front end holds ready low while the job queue is full or both line
// banks still wait for readout. Reset is synchronous and needs no sweep.
`default_nettype none
module command_line_assembler #(
    parameter int CAPACITY = cla_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cla_in_if.sink                         i_cmd,
    cla_out_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cla_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cla_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cla_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cla_pkg::*;

    localparam int LW    = $clog2(CAPACITY);
    localparam int AW    = $clog2(2 * CAPACITY);
    localparam int JW    = LW + 2;
    localparam int DEPTH = 2 * CAPACITY;

    logic [IDLE_W-1:0] r_idle_ticks;
    logic              cfg_wr;

    logic              push;
    logic [JW-1:0]     job_in;
    logic [JW-1:0]     job_out;
    logic              pop;
    t_q_stat           qstat;
    logic              line_done;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [CHAR_W-1:0] rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= IDLE_TICKS_RESET;
        end else if (cfg_wr) begin
            r_idle_ticks <= pwdata[IDLE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDLE_TICKS) ? APB_DATA_W'(r_idle_ticks) : '0;

    cla_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_idle_ticks (r_idle_ticks),
        .i_qstat      (qstat),
        .i_line_done  (line_done),
        .o_push       (push),
        .o_job        (job_in),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    cla_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (qstat)
    );

    cla_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cla_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_line_done (line_done),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

### rtl/core/cla_checker.sv
// Port-level checker for the command line assembler, bound to the top level.
`default_nettype none
`include "command_line_assembler_assert.svh"
module cla_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_kind,
    input logic [cla_pkg::CHAR_W-1:0]   i_char_out,
    input logic                         i_last
);
    import cla_pkg::*;

    `CLA_ASSERT_ALWAYS(a_no_result_after_reset, !i_rst_n |=> !i_valid, "result valid after reset")

    `CLA_ASSERT(a_err_shape, i_valid && (i_kind == KIND_ERR) |-> (i_char_out == '0) && i_last, "error item must carry zero char and last")

    `CLA_ASSERT(a_char_printable, i_valid && (i_kind == KIND_CHAR) |-> (i_char_out >= CHAR_W'(PRINT_LOW)) && (i_char_out <= CHAR_W'(PRINT_HIGH)), "line character not printable")

    `CLA_ASSERT(a_hold_stalled, i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_char_out) && $stable(i_last), "stalled result changed")

endmodule

bind command_line_assembler cla_checker u_cla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_res.valid),
    .i_ready    (o_res.ready),
    .i_kind     (o_res.kind),
    .i_char_out (o_res.char_out),
    .i_last     (o_res.last)
);
`default_nettype wire

### test/tb_command_line_assembler.sv
// Testbench for the command line assembler: random byte and tick items checked against a line predictor.
`timescale 1ns / 1ps
module tb_command_line_assembler;
    import cla_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam logic [APB_ADDR_W-1:0] IDLE_TICKS_ADDR = {REG_IDLE_TICKS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR   = {~REG_IDLE_TICKS, 2'b00};

    typedef enum int {END_CR, END_LF, END_IDLE, END_NONE} t_line_end;

    class t_line_tracker;
        typedef struct {
            logic              kind;
            logic [CHAR_W-1:0] ch;
            logic              last;
        } t_line_result;

        logic [CHAR_W-1:0] line_chars[CAPACITY_DEF];
        int unsigned       line_len;
        bit                discarding;
        logic [IDLE_W-1:0] idle_count;
        logic [IDLE_W-1:0] idle_limit;
        t_line_result      line_results_due[$];
        int                fails;

        function new();
            line_len   = 0;
            discarding = 1'b0;
            idle_count = '0;
            idle_limit = IDLE_TICKS_RESET;
            fails      = 0;
        endfunction

        function void set_idle_limit(logic [IDLE_W-1:0] value);
            idle_limit = value;
        endfunction

        function int pending();
            return line_results_due.size();
        endfunction

        function void flush_line();
            t_line_result r;
            for (int k = 0; k < line_len; k++) begin
                r.kind = KIND_CHAR;
                r.ch   = line_chars[k];
                r.last = (k == line_len - 1);
                line_results_due.push_back(r);
            end
        endfunction

        function void take_item(logic op, logic [RX_W-1:0] b);
            t_line_result r;
            if (op == OP_BYTE) begin
                idle_count = '0;
                if (b == CH_CR || b == CH_LF) begin
                    if (!discarding && line_len > 0) begin
                        flush_line();
                    end
                    line_len   = 0;
                    discarding = 1'b0;
                end else if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
                    if (line_len + 1 < CAPACITY_DEF) begin
                        if (!discarding) begin
                            line_chars[line_len] = b[CHAR_W-1:0];
                            line_len++;
                        end
                    end else begin
                        discarding = 1'b1;
                    end
                end
            end else begin
                if (idle_count != IDLE_MAX) begin
                    idle_count++;
                end
                if (idle_count >= idle_limit) begin
                    if (discarding) begin
                        r.kind = KIND_ERR;
                        r.ch   = '0;
                        r.last = 1'b1;
                        line_results_due.push_back(r);
                        line_len   = 0;
                        discarding = 1'b0;
                    end else if (line_len > 0) begin
                        flush_line();
                        line_len = 0;
                    end
                end
            end
        endfunction

        function void check_result(logic kind, logic [CHAR_W-1:0] ch, logic last);
            t_line_result want;
            if (line_results_due.size() == 0) begin
                $error("unexpected result: kind %0d char_out 0x%0h last %0d", kind, ch, last);
                fails++;
                return;
            end
            want = line_results_due.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                fails++;
            end
            if (ch !== want.ch) begin
                $error("char_out: expected 0x%0h, got 0x%0h", want.ch, ch);
                fails++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cla_in_if  cmd();
    cla_out_if res();

    t_line_tracker tracker = new();
    int            items_sent = 0;
    bit            gaps_on = 1'b1;
    int            stall_pct = 10;

    command_line_assembler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side in random bursts.
    initial begin
        int hold;
        hold = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                res.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                hold = pick_gap() - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            tracker.check_result(res.kind, res.char_out, res.last);
        end
    end

    task send_item(logic op, logic [RX_W-1:0] b);
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd.valid   <= 1'b1;
        cmd.op      <= op;
        cmd.rx_byte <= b;
        do @(posedge i_clk); while (!cmd.ready);
        tracker.take_item(op, b);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result is out.
    task settle();
        cmd.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == IDLE_TICKS_ADDR) begin
            tracker.set_idle_limit(data[IDLE_W-1:0]);
        end
    endtask

    task verify_idle();
        logic [APB_DATA_W-1:0] data;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= IDLE_TICKS_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data[IDLE_W-1:0] !== tracker.idle_limit) begin
            $error("idle_ticks: expected %0d, got %0d", tracker.idle_limit, data[IDLE_W-1:0]);
            tracker.fails++;
        end
    endtask

    task set_idle(logic [IDLE_W-1:0] value);
        settle();
        apb_write(IDLE_TICKS_ADDR, {{(APB_DATA_W-IDLE_W){1'b0}}, value});
        verify_idle();
    endtask

    task run_line(int len, t_line_end ending, bit clean);
        logic [RX_W-1:0] b;
        int              ticks;
        for (int i = 0; i < len; i++) begin
            if (!clean && $urandom_range(0, 9) == 0) begin
                b = RX_W'($urandom_range(0, 255));
            end else begin
                b = RX_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
            end
            send_item(OP_BYTE, b);
            if (!clean && $urandom_range(0, 24) == 0) begin
                send_item(OP_TICK, RX_W'($urandom_range(0, 255)));
            end
        end
        case (ending)
            END_CR: begin
                send_item(OP_BYTE, CH_CR);
            end
            END_LF: begin
                send_item(OP_BYTE, CH_LF);
            end
            END_IDLE: begin
                // reach the idle limit only when it is cheap to do so
                if (tracker.idle_limit <= 20) begin
                    ticks = tracker.idle_limit + $urandom_range(0, 2);
                end else begin
                    ticks = $urandom_range(1, 5);
                end
                repeat (ticks) send_item(OP_TICK, RX_W'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
    endtask

    task run_phase(int budget);
        int        first;
        int        len;
        int        pick;
        t_line_end ending;
        first = items_sent;
        while (items_sent - first < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) len = 0;
            else if (pick < 55) len = $urandom_range(1, 10);
            else if (pick < 75) len = $urandom_range(11, 40);
            else if (pick < 90) len = $urandom_range(58, 63);
            else len = $urandom_range(64, 75);
            pick = $urandom_range(0, 99);
            if (pick < 35) ending = END_CR;
            else if (pick < 60) ending = END_LF;
            else if (pick < 85) ending = END_IDLE;
            else ending = END_NONE;
            run_line(len, ending, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        cmd.valid   <= 1'b0;
        cmd.op      <= OP_BYTE;
        cmd.rx_byte <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // printable bounds, both line ends, empty lines, ignored bytes
        send_item(OP_BYTE, PRINT_LOW);
        send_item(OP_BYTE, PRINT_HIGH);
        send_item(OP_BYTE, CH_CR);
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BYTE, CH_LF);
        send_item(OP_BYTE, CH_CR);
        send_item(OP_BYTE, CH_LF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h1F);
        send_item(OP_BYTE, 8'h7F);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_BYTE, 8'h61);
        send_item(OP_BYTE, CH_CR);
        repeat (3) send_item(OP_TICK, 8'h00);

        // shortest idle limit: flush on one tick, then nothing more
        set_idle(16'd1);
        send_item(OP_BYTE, 8'h71);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'h00);

        // full line, then an overlong line dropped by idle
        run_line(63, END_CR, 1'b1);
        run_line(64, END_IDLE, 1'b1);
        run_phase(20);

        settle();
        apb_write(UNMAPPED_ADDR, $urandom);
        verify_idle();

        // longest idle limit, no idling on either side
        set_idle(IDLE_MAX);
        gaps_on   = 1'b0;
        stall_pct = 0;
        run_phase(15);
        send_item(OP_BYTE, CH_CR);
        run_line(2, END_NONE, 1'b1);
        // a few ticks stay far below the limit, so the line stays pending
        repeat (5) send_item(OP_TICK, RX_W'($urandom_range(0, 255)));

        gaps_on   = 1'b1;
        stall_pct = 35;
        set_idle(IDLE_W'($urandom_range(2, 20)));
        run_phase(20);

        stall_pct = 15;
        set_idle(IDLE_TICKS_RESET);
        run_phase(20);

        settle();
        if (tracker.fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### command_line_assembler.f
+incdir+rtl/core
rtl/core/cla_pkg.sv
rtl/core/cla_if.sv
rtl/core/cla_ram.sv
rtl/core/cla_front.sv
rtl/core/cla_queue.sv
rtl/core/cla_back.sv
rtl/core/command_line_assembler.sv
rtl/core/cla_checker.sv
test/tb_command_line_assembler.sv
